// ===== design/stip_pkg.sv =====
// shared types and constants of the string to integer parser
package stip_pkg;

  // accumulator width, the value wraps modulo 2^VALUE_WIDTH
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned PARSED_W    = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned BASE_W      = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // register map
  localparam logic [PADDR_W-1:0] ADDR_BASE_SETTING = 3'd0;

  // character codes
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  // bases picked by the prefix rules
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  // letters start at digit value ten
  localparam logic [BASE_W-1:0] LETTER_OFFSET = 6'd10;

  // parse phases
  typedef enum logic [2:0] {
    PH_DONE   = 3'd0,
    PH_SPACE  = 3'd1,
    PH_SIGNED = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } phase_e;

endpackage

// ===== design/string_to_integer_parser_core.sv =====
// top level of the string to integer parser: input register, parse step and result register
//
// The parser takes one character per clock cycle and keeps that rate as long as results are
// taken. An accepted character sits in the input register while the parse step (prefix and
// sign rules, one 32 by 6 bit multiply-add with overflow check) updates the parse state; the
// stopping character passes through the input register and then loads the result register.
// Only a held result stalls the input register, which still takes one more character
// meanwhile. The base register (address 0) is sampled at each first character of a string;
// the user must write it only while idle, and the block itself does not enforce this.
module string_to_integer_parser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [stip_pkg::PADDR_W-1:0]    paddr,
  input  logic [stip_pkg::PDATA_W-1:0]    pwdata,
  output logic [stip_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // character channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [stip_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                            first_char_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [stip_pkg::PARSED_W-1:0] parsed_value_o,
  output logic [stip_pkg::COUNT_W-1:0]    consumed_count_o,
  output logic                            overflow_seen_o
);
  import stip_pkg::*;

  localparam int unsigned MAC_W = VALUE_WIDTH + BASE_W + 1;

  logic [BASE_W-1:0]      base_q;
  logic                   in_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   first_q;
  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [BASE_W-1:0]      wbase_q, wbase_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic                   out_valid_q;
  logic [PARSED_W-1:0]    value_q;
  logic [COUNT_W-1:0]     count_q;
  logic                   ovf_out_q;

  logic                   advance;
  logic                   emit;
  phase_e                 ph_cur;
  logic                   neg_cur;
  logic [BASE_W-1:0]      wb_cur;
  logic [VALUE_WIDTH-1:0] acc_cur;
  logic [COUNT_W-1:0]     cnt_cur;
  logic                   ovf_cur;
  logic [COUNT_W-1:0]     cnt_inc;
  logic                   is_digit, is_lower, is_upper;
  logic [BASE_W-1:0]      dig;
  logic [BASE_W-1:0]      dig_base;
  logic                   dig_ok;
  logic [MAC_W-1:0]       mac;
  logic                   lead_zero;
  logic [VALUE_WIDTH-1:0] signed_val;

  // apb register access
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_BASE_SETTING) begin
      prdata = PDATA_W'(base_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_AUTO;
    end else if (psel && penable && pwrite && (paddr == ADDR_BASE_SETTING)) begin
      base_q <= pwdata[BASE_W-1:0];
    end
  end

  // handshake: the input register drains when the result register can take a result
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q  <= char_code_i;
      first_q <= first_char_i;
    end
  end

  // state as seen by this character, a first character restarts it
  always_comb begin
    ph_cur  = phase_q;
    neg_cur = neg_q;
    wb_cur  = wbase_q;
    acc_cur = acc_q;
    cnt_cur = cnt_q;
    ovf_cur = ovf_q;
    if (first_q) begin
      ph_cur  = PH_SPACE;
      neg_cur = 1'b0;
      wb_cur  = base_q;
      acc_cur = '0;
      cnt_cur = '0;
      ovf_cur = 1'b0;
    end
  end

  // saturating character count
  assign cnt_inc = (cnt_cur == {COUNT_W{1'b1}}) ? cnt_cur : cnt_cur + COUNT_W'(1);

  // digit decode
  assign is_digit = (char_q >= CH_0)  && (char_q <= CH_9);
  assign is_lower = (char_q >= CH_LA) && (char_q <= CH_LZ);
  assign is_upper = (char_q >= CH_UA) && (char_q <= CH_UZ);

  always_comb begin
    dig = '0;
    if (is_digit) begin
      dig = BASE_W'(char_q - CH_0);
    end else if (is_lower) begin
      dig = BASE_W'(char_q - CH_LA) + LETTER_OFFSET;
    end else if (is_upper) begin
      dig = BASE_W'(char_q - CH_UA) + LETTER_OFFSET;
    end
  end

  // leading zero may open a hex prefix or pick octal
  assign lead_zero = (char_q == CH_0) && ((wb_cur == BASE_AUTO) || (wb_cur == BASE_HEX));

  // base used for a digit, with the auto base resolved for this phase
  always_comb begin
    case (ph_cur)
      PH_SPACE, PH_SIGNED: dig_base = (wb_cur == BASE_AUTO) ? BASE_DEC : wb_cur;
      PH_ZERO:             dig_base = (wb_cur == BASE_AUTO) ? BASE_OCT : wb_cur;
      default:             dig_base = wb_cur;
    endcase
  end

  assign dig_ok = (is_digit || is_lower || is_upper) && (dig < dig_base);

  // multiply-add, anything above the value width is overflow
  assign mac = MAC_W'(acc_cur) * MAC_W'(dig_base) + MAC_W'(dig);

  // one parse step
  always_comb begin
    logic do_digit;
    do_digit = 1'b0;
    phase_d  = ph_cur;
    neg_d    = neg_cur;
    wbase_d  = wb_cur;
    acc_d    = acc_cur;
    cnt_d    = cnt_cur;
    ovf_d    = ovf_cur;
    emit     = 1'b0;
    case (ph_cur)
      PH_SPACE: begin
        if ((char_q == CH_SPACE) || (char_q == CH_TAB)) begin
          cnt_d = cnt_inc;
        end else if ((char_q == CH_PLUS) || (char_q == CH_MINUS)) begin
          neg_d   = (char_q == CH_MINUS);
          cnt_d   = cnt_inc;
          phase_d = PH_SIGNED;
        end else if (lead_zero) begin
          cnt_d   = cnt_inc;
          acc_d   = '0;
          phase_d = PH_ZERO;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_SIGNED: begin
        if (lead_zero) begin
          cnt_d   = cnt_inc;
          acc_d   = '0;
          phase_d = PH_ZERO;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (char_q == CH_X) begin
          cnt_d   = cnt_inc;
          wbase_d = BASE_HEX;
          phase_d = PH_DIGITS;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      default:   do_digit = 1'b0;
    endcase
    if (do_digit) begin
      wbase_d = dig_base;
      if (dig_ok) begin
        ovf_d   = ovf_cur || (|mac[MAC_W-1:VALUE_WIDTH]);
        acc_d   = mac[VALUE_WIDTH-1:0];
        cnt_d   = cnt_inc;
        phase_d = PH_DIGITS;
      end else begin
        emit    = 1'b1;
        phase_d = PH_DONE;
      end
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      neg_q   <= 1'b0;
      wbase_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      wbase_q <= wbase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // result register
  assign signed_val = neg_cur ? (VALUE_WIDTH'(0) - acc_cur) : acc_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      value_q   <= PARSED_W'(signed_val);
      count_q   <= cnt_cur;
      ovf_out_q <= ovf_cur;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign parsed_value_o   = value_q;
  assign consumed_count_o = count_q;
  assign overflow_seen_o  = ovf_out_q;

`ifndef NO_ASSERTIONS
  // an empty input register always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  // a new result only comes from a character that left the input register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && emit))
    else $error("result appeared without a stopping character");

  // after a result the parse waits for the next start
  a_done_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> phase_q == PH_DONE)
    else $error("parse not finished after result");

  // within a string the count never falls
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !first_q |=> cnt_q >= $past(cnt_q))
    else $error("character count decreased");

  // the overflow flag is sticky within a string
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !first_q && ovf_q |=> ovf_q)
    else $error("overflow flag cleared mid string");
`endif

endmodule

// ===== sim/string_to_integer_parser_core_tb.sv =====
// self-checking testbench of the string to integer parser core
`timescale 1ns / 1ps

module string_to_integer_parser_core_tb;
  import stip_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEMS_PER_BASE = 68;

  // an unmapped register slot, writes there must leave the base alone
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  // one expected result transaction
  typedef struct packed {
    logic signed [PARSED_W-1:0] parsed;
    logic [COUNT_W-1:0]         consumed;
    logic                       overflow;
  } parse_result_t;

  localparam parse_result_t NONE_DUE = '0;

  // one directed character, with its result typed in where it is obvious
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              first;
    logic              pinned;
    parse_result_t     want;
  } char_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [PDATA_W-1:0]         pwdata = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [CHAR_W-1:0]          char_code_i = '0;
  logic                       first_char_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [PARSED_W-1:0] parsed_value_o;
  logic [COUNT_W-1:0]         consumed_count_o;
  logic                       overflow_seen_o;

  string_to_integer_parser_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .first_char_i     (first_char_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .parsed_value_o   (parsed_value_o),
    .consumed_count_o (consumed_count_o),
    .overflow_seen_o  (overflow_seen_o)
  );

  // clock
  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // parser state as predicted, plus our copy of the base register
  logic [BASE_W-1:0]      base_reg = BASE_AUTO;
  phase_e                 phase_now;
  logic                   minus_seen;
  logic [BASE_W-1:0]      digit_base;
  logic [VALUE_WIDTH-1:0] acc_value;
  logic [COUNT_W-1:0]     chars_taken;
  logic                   wrapped_seen;

  parse_result_t expected_results[$];
  parse_result_t oldest;
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            burst_left = 0;
  bit            sender_gaps = 1'b1;
  int            rx_mode = 0;
  int            rx_left = 0;
  int            rx_tick = 0;

  // directed strings, all parsed with base detection from the prefix
  char_row_t directed_rows [23] = '{
    // stray byte before any start is ignored
    '{8'h41,     1'b0, 1'b0, NONE_DUE},
    // blanks, minus and hex prefix, stops on a letter just past hex range
    '{CH_SPACE,  1'b1, 1'b0, NONE_DUE},
    '{CH_TAB,    1'b0, 1'b0, NONE_DUE},
    '{CH_MINUS,  1'b0, 1'b0, NONE_DUE},
    '{CH_0,      1'b0, 1'b0, NONE_DUE},
    '{CH_X,      1'b0, 1'b0, NONE_DUE},
    '{"f",       1'b0, 1'b0, NONE_DUE},
    '{"G",       1'b0, 1'b1, '{-32'sd15, 16'd6, 1'b0}},
    // hex prefix with no digits after it
    '{CH_0,      1'b1, 1'b0, NONE_DUE},
    '{CH_X,      1'b0, 1'b0, NONE_DUE},
    '{"!",       1'b0, 1'b1, '{32'sd0, 16'd2, 1'b0}},
    // sign and nothing else
    '{CH_PLUS,   1'b1, 1'b0, NONE_DUE},
    '{";",       1'b0, 1'b1, '{32'sd0, 16'd1, 1'b0}},
    // leading zero turns octal, nine stops it
    '{CH_0,      1'b1, 1'b0, NONE_DUE},
    '{"7",       1'b0, 1'b0, NONE_DUE},
    '{CH_9,      1'b0, 1'b1, '{32'sd7, 16'd2, 1'b0}},
    // restart in the middle drops the unfinished string
    '{"1",       1'b1, 1'b0, NONE_DUE},
    '{"2",       1'b0, 1'b0, NONE_DUE},
    '{CH_LZ,     1'b1, 1'b1, '{32'sd0, 16'd0, 1'b0}},
    // bytes after a result are ignored until the next start
    '{8'hff,     1'b0, 1'b0, NONE_DUE},
    '{8'h00,     1'b0, 1'b0, NONE_DUE},
    // byte extremes as starting characters
    '{8'h00,     1'b1, 1'b1, '{32'sd0, 16'd0, 1'b0}},
    '{8'hff,     1'b1, 1'b1, '{32'sd0, 16'd0, 1'b0}}
  };

  function automatic void count_char();
    if (chars_taken != '1) chars_taken++;
  endfunction

  // digit accumulation, or the result on a byte that is not a digit of the base
  function automatic bit take_digit(input logic [CHAR_W-1:0] code, output parse_result_t res);
    logic [BASE_W-1:0]             dig;
    bit                            is_digit;
    logic [VALUE_WIDTH+BASE_W:0]   wide;
    logic [VALUE_WIDTH-1:0]        signed_acc;
    res = NONE_DUE;
    is_digit = 1'b1;
    dig = '0;
    if (code >= CH_0 && code <= CH_9) dig = BASE_W'(code - CH_0);
    else if (code >= CH_LA && code <= CH_LZ) dig = BASE_W'(code - CH_LA) + LETTER_OFFSET;
    else if (code >= CH_UA && code <= CH_UZ) dig = BASE_W'(code - CH_UA) + LETTER_OFFSET;
    else is_digit = 1'b0;
    if (!is_digit || dig >= digit_base) begin
      signed_acc = minus_seen ? (~acc_value + 1'b1) : acc_value;
      res.parsed = PARSED_W'(signed_acc);
      res.consumed = chars_taken;
      res.overflow = wrapped_seen;
      phase_now = PH_DONE;
      return 1'b1;
    end
    wide = acc_value * digit_base + dig;
    if (wide[VALUE_WIDTH+BASE_W:VALUE_WIDTH] != '0) wrapped_seen = 1'b1;
    acc_value = wide[VALUE_WIDTH-1:0];
    count_char();
    phase_now = PH_DIGITS;
    return 1'b0;
  endfunction

  // first character after blanks and sign, a zero may open a prefix
  function automatic bit lead_char(input logic [CHAR_W-1:0] code, output parse_result_t res);
    res = NONE_DUE;
    if (code == CH_0 && (digit_base == BASE_AUTO || digit_base == BASE_HEX)) begin
      count_char();
      acc_value = '0;
      phase_now = PH_ZERO;
      return 1'b0;
    end
    if (digit_base == BASE_AUTO) digit_base = BASE_DEC;
    return take_digit(code, res);
  endfunction

  // predicts the parser for one accepted character
  function automatic bit step_parser(input logic [CHAR_W-1:0] code, input logic first,
                                     output parse_result_t res);
    res = NONE_DUE;
    if (first) begin
      phase_now = PH_SPACE;
      minus_seen = 1'b0;
      digit_base = base_reg;
      acc_value = '0;
      chars_taken = '0;
      wrapped_seen = 1'b0;
    end
    case (phase_now)
      PH_SPACE: begin
        if (code == CH_SPACE || code == CH_TAB) begin
          count_char();
          return 1'b0;
        end
        if (code == CH_PLUS || code == CH_MINUS) begin
          minus_seen = (code == CH_MINUS);
          count_char();
          phase_now = PH_SIGNED;
          return 1'b0;
        end
        return lead_char(code, res);
      end
      PH_SIGNED: return lead_char(code, res);
      PH_ZERO: begin
        if (code == CH_X) begin
          count_char();
          digit_base = BASE_HEX;
          phase_now = PH_DIGITS;
          return 1'b0;
        end
        if (digit_base == BASE_AUTO) digit_base = BASE_OCT;
        return take_digit(code, res);
      end
      PH_DIGITS: return take_digit(code, res);
      default: return 1'b0;
    endcase
  endfunction

  // drives one character transaction in bursts and records what it should give
  task automatic send_char(input logic [CHAR_W-1:0] code, input logic first,
                           input logic pinned = 1'b0, input parse_result_t want = NONE_DUE);
    parse_result_t got;
    bit            made;
    @(negedge clk_i);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    char_code_i <= code;
    first_char_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    made = step_parser(code, first, got);
    if (pinned) expected_results.push_back(want);
    else if (made) expected_results.push_back(got);
  endtask

  // sender holds off until every expected result has come back
  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, setup then access cycle
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_BASE_SETTING) base_reg = data[BASE_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // read the base register back and compare with our copy
  task automatic check_base_readback();
    logic [PDATA_W-1:0] got;
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ADDR_BASE_SETTING;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got !== PDATA_W'(base_reg)) begin
      $error("base_setting: expected %0d, got %0d", base_reg, got);
      mismatches++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // one random string: mostly well formed numbers, some noise and broken ones
  task automatic send_string(inout int taken);
    logic              first;
    int                eff_base;
    int                n_dig;
    int                pick;
    int                dval;
    logic [CHAR_W-1:0] code;
    first = 1'b1;
    pick = $urandom_range(0, 15);
    // noise with stray start marks
    if (pick < 2) begin
      repeat ($urandom_range(1, 6)) begin
        send_char(CHAR_W'($urandom_range(0, 255)), first);
        first = ($urandom_range(0, 3) == 0);
        taken++;
      end
      return;
    end
    if (pick == 2) wait_results();
    // leading blanks and sign
    repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0) begin
      send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, first);
      first = 1'b0;
      taken++;
    end
    pick = $urandom_range(0, 2);
    if (pick != 0) begin
      send_char((pick == 1) ? CH_PLUS : CH_MINUS, first);
      first = 1'b0;
      taken++;
    end
    // prefix where the base allows one
    eff_base = base_reg;
    if (base_reg == BASE_AUTO || base_reg == BASE_HEX) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        send_char(CH_0, first);
        send_char(CH_X, 1'b0);
        first = 1'b0;
        taken += 2;
        eff_base = BASE_HEX;
      end else if (pick == 1) begin
        send_char(CH_0, first);
        first = 1'b0;
        taken++;
        if (base_reg == BASE_AUTO) eff_base = BASE_OCT;
      end else if (base_reg == BASE_AUTO) begin
        eff_base = BASE_DEC;
      end
    end
    // digits of the base, long runs to force wrapping
    n_dig = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
    repeat (n_dig) begin
      if (eff_base <= 1) dval = 0;
      else if (eff_base > 36) dval = $urandom_range(0, 35);
      else dval = $urandom_range(0, eff_base - 1);
      if (dval < 10) code = CHAR_W'(CH_0 + dval);
      else code = CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + dval - 10);
      send_char(code, first);
      first = 1'b0;
      taken++;
    end
    // stopping byte, sometimes left out so that the next start abandons the string
    if ($urandom_range(0, 7) != 0) begin
      send_char(CHAR_W'($urandom_range(0, 255)), first);
      taken++;
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // receiver stalls, switching between patterns
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= (rx_tick % 7) < 4;
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: parsed_value %0d, consumed_count %0d",
               parsed_value_o, consumed_count_o);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        if (oldest.parsed !== parsed_value_o) begin
          $error("parsed_value: expected %0d, got %0d", oldest.parsed, parsed_value_o);
          mismatches++;
        end
        if (oldest.consumed !== consumed_count_o) begin
          $error("consumed_count: expected %0d, got %0d", oldest.consumed, consumed_count_o);
          mismatches++;
        end
        if (oldest.overflow !== overflow_seen_o) begin
          $error("overflow_seen: expected %0d, got %0d", oldest.overflow, overflow_seen_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    logic [BASE_W-1:0]  phase_bases [10];
    logic [PDATA_W-1:0] wdata;
    int                 sent;
    phase_now = PH_DONE;
    minus_seen = 1'b0;
    digit_base = '0;
    acc_value = '0;
    chars_taken = '0;
    wrapped_seen = 1'b0;
    phase_bases = '{BASE_DEC, BASE_HEX, BASE_OCT, 6'd2, 6'd36, 6'd1, 6'd37, 6'd63, 6'd0,
                    BASE_AUTO};
    phase_bases[8] = BASE_W'($urandom_range(0, 63));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of the base, then the directed strings
    check_base_readback();
    foreach (directed_rows[k])
      send_char(directed_rows[k].code, directed_rows[k].first, directed_rows[k].pinned,
                directed_rows[k].want);

    // random strings under each base setting
    foreach (phase_bases[i]) begin
      wait_idle();
      wdata = $urandom;
      wdata[BASE_W-1:0] = phase_bases[i];
      write_reg(ADDR_BASE_SETTING, wdata);
      if (i == 3) write_reg(ADDR_UNMAPPED, $urandom);
      check_base_readback();
      sender_gaps = (i != 5);
      sent = 0;
      while (sent < ITEMS_PER_BASE) send_string(sent);
      sender_gaps = 1'b1;
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== string_to_integer_parser_core.f =====
design/stip_pkg.sv
design/string_to_integer_parser_core.sv
sim/string_to_integer_parser_core_tb.sv
